>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// clocked assertion helpers with a common reset disable
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_AT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_AT(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

>>> rtl/core/apwg_pkg.sv
// ----------------------------------------------------------------------------
// apwg_pkg
// shared constants, codes and types of the action potential waveform core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package apwg_pkg;

    localparam int TIME_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 8;

    localparam int CFG_W   = 32;
    localparam int IDX_W   = 2;
    localparam int PER_W   = 24;
    localparam int VOLT_W  = 16;

    localparam logic [IDX_W-1:0] REG_STIM_BEGIN = 2'd0;
    localparam logic [IDX_W-1:0] REG_STIM_END   = 2'd1;
    localparam logic [IDX_W-1:0] REG_PERIOD     = 2'd2;
    localparam logic [IDX_W-1:0] REG_REST       = 2'd3;

    localparam int MIN_PERIOD   = 10000;
    localparam int PER_MIN_LOG2 = $clog2(MIN_PERIOD + 1) - 1;
    localparam int REST_RESET   = -16640;

    // segment codes
    localparam int SEG_W = 3;
    localparam logic [SEG_W-1:0] SEG_REST  = 3'd0;
    localparam logic [SEG_W-1:0] SEG_RISE  = 3'd1;
    localparam logic [SEG_W-1:0] SEG_UP    = 3'd2;
    localparam logic [SEG_W-1:0] SEG_DOWN  = 3'd3;
    localparam logic [SEG_W-1:0] SEG_RECOV = 3'd4;

    // segment start times in us
    localparam int T_RISE  = 1000;
    localparam int T_UP    = 2500;
    localparam int T_DOWN  = 3000;
    localparam int T_RECOV = 4500;
    localparam int T_END   = 7000;

    // slopes in mV/s
    localparam int SL_W        = 18;
    localparam int SLOPE_RISE  = 8000;
    localparam int SLOPE_UP    = 160000;
    localparam int SLOPE_DOWN  = 62000;
    localparam int SLOPE_RECOV = 400;

    // segment base voltages in whole mV
    localparam int MV_UP    = -53;
    localparam int MV_DOWN  = 27;
    localparam int MV_RECOV = -66;

    localparam int D_W          = 12;
    localparam int P_W          = 27;
    localparam int ROUND_HALF   = 500000;
    localparam int DIV_SHIFT    = 6;
    localparam int DIV_ODD      = 15625;
    localparam int SHAPE_STAGES = 7;

    typedef struct packed {
        logic             valid;
        logic             in_win;
        logic [PER_W-1:0] t;
    } apwg_mod_out_t;

    function automatic logic [SL_W-1:0] slope_of(input logic [SEG_W-1:0] seg);
        logic [SL_W-1:0] s;
        case (seg)
            SEG_RISE:  s = SL_W'(SLOPE_RISE);
            SEG_UP:    s = SL_W'(SLOPE_UP);
            SEG_DOWN:  s = SL_W'(SLOPE_DOWN);
            SEG_RECOV: s = SL_W'(SLOPE_RECOV);
            default:   s = '0;
        endcase
        return s;
    endfunction

endpackage

>>> rtl/core/apwg_mod.sv
// ----------------------------------------------------------------------------
// apwg_mod
// window check and pipelined restoring remainder of time by period
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module apwg_mod #(
    parameter int TIME_BITS = apwg_pkg::TIME_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [TIME_BITS-1:0]       in_time,
    input  logic [TIME_BITS-1:0]       win_begin,
    input  logic [TIME_BITS-1:0]       win_end,
    input  logic [apwg_pkg::PER_W-1:0] period,
    output apwg_pkg::apwg_mod_out_t    mod_out
);
    import apwg_pkg::*;

    localparam int NDIV   = TIME_BITS - PER_MIN_LOG2;
    localparam int WIDE_W = TIME_BITS + PER_W;

    logic [TIME_BITS-1:0] rem_reg [0:NDIV];
    logic                 win_reg [0:NDIV];
    logic                 val_reg [0:NDIV];
    logic                 win_next;

    assign win_next = (in_time >= win_begin) && (in_time <= win_end);

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= in_time;
        win_reg[0] <= win_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg[0] <= 1'b0;
        end
        else
        begin
            val_reg[0] <= in_valid;
        end
    end

    // one quotient bit per stage, most significant first
    for (genvar i = 1; i <= NDIV; i++)
    begin : g_div
        localparam int SH = NDIV - i;
        logic [WIDE_W-1:0]    dsh;
        logic [WIDE_W-1:0]    rem_w;
        logic [TIME_BITS-1:0] rem_next;

        always_comb
        begin
            dsh   = {{TIME_BITS{1'b0}}, period} << SH;
            rem_w = {{PER_W{1'b0}}, rem_reg[i-1]};
            if (rem_w >= dsh)
            begin
                rem_next = TIME_BITS'(rem_w - dsh);
            end
            else
            begin
                rem_next = rem_reg[i-1];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[i] <= rem_next;
            win_reg[i] <= win_reg[i-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                val_reg[i] <= 1'b0;
            end
            else
            begin
                val_reg[i] <= val_reg[i-1];
            end
        end
    end

    assign mod_out.valid  = val_reg[NDIV];
    assign mod_out.in_win = win_reg[NDIV];
    assign mod_out.t      = rem_reg[NDIV][PER_W-1:0];

endmodule

>>> rtl/core/apwg_shape.sv
// ----------------------------------------------------------------------------
// apwg_shape
// piecewise-linear spike shape with rounded fixed-point ramps and saturation
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module apwg_shape #(
    parameter int FRAC_BITS = apwg_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  apwg_pkg::apwg_mod_out_t            mod_in,
    input  logic signed [apwg_pkg::VOLT_W-1:0] rest,
    output logic                               res_valid,
    output logic signed [apwg_pkg::VOLT_W-1:0] res_volt
);
    import apwg_pkg::*;

    localparam int N_W   = P_W + FRAC_BITS + 1;
    localparam int X_W   = N_W - DIV_SHIFT;
    localparam int Q_W   = X_W - 13;
    localparam int SUM_W = FRAC_BITS + 14;

    localparam logic [Q_W-1:0] RECIP = Q_W'((64'd1 << X_W) / 64'(DIV_ODD));

    localparam logic signed [SUM_W-1:0] BASE_UP    = SUM_W'(MV_UP * (2 ** FRAC_BITS));
    localparam logic signed [SUM_W-1:0] BASE_DOWN  = SUM_W'(MV_DOWN * (2 ** FRAC_BITS));
    localparam logic signed [SUM_W-1:0] BASE_RECOV = SUM_W'(MV_RECOV * (2 ** FRAC_BITS));
    localparam logic signed [SUM_W-1:0] SAT_HI     = SUM_W'(32767);
    localparam logic signed [SUM_W-1:0] SAT_LO     = SUM_W'(-32768);

    logic [SHAPE_STAGES:1] val_reg;

    logic [SEG_W-1:0] seg1_reg, seg2_reg, seg3_reg, seg4_reg, seg5_reg, seg6_reg;
    logic [SEG_W-1:0] seg1_next;
    logic [D_W-1:0]   d1_reg, d1_next;
    logic [P_W-1:0]   p2_reg, p2_next;
    logic [X_W-1:0]   x3_reg, x4_reg, x5_reg, x3_next;
    logic [X_W+Q_W-1:0] m4_reg, m4_next;
    logic [Q_W-1:0]   q5_reg, q6_reg, q6_next;
    logic [X_W-1:0]   qd5_reg, qd5_next;
    logic signed [VOLT_W-1:0] volt_reg, volt_next;

    logic [PER_W-1:0]     t;
    logic [SL_W+D_W-1:0]  prod_full;
    logic [N_W-1:0]       num;
    logic [Q_W+13:0]      qd_full;
    logic [X_W-1:0]       rem;
    logic signed [SUM_W-1:0] rest_ext, qs, sum;

    // segment select
    always_comb
    begin
        t         = mod_in.t;
        seg1_next = SEG_REST;
        d1_next   = '0;
        if (mod_in.in_win && t >= PER_W'(T_RISE) && t < PER_W'(T_END))
        begin
            if (t < PER_W'(T_UP))
            begin
                seg1_next = SEG_RISE;
                d1_next   = D_W'(t - PER_W'(T_RISE));
            end
            else if (t < PER_W'(T_DOWN))
            begin
                seg1_next = SEG_UP;
                d1_next   = D_W'(t - PER_W'(T_UP));
            end
            else if (t < PER_W'(T_RECOV))
            begin
                seg1_next = SEG_DOWN;
                d1_next   = D_W'(t - PER_W'(T_DOWN));
            end
            else
            begin
                seg1_next = SEG_RECOV;
                d1_next   = D_W'(t - PER_W'(T_RECOV));
            end
        end
    end

    // ramp magnitude, rounded: (slope * d * 2^F + 1e6/2) / 1e6
    always_comb
    begin
        prod_full = slope_of(seg1_reg) * d1_reg;
        p2_next   = P_W'(prod_full);
        num       = {1'b0, p2_reg, {FRAC_BITS{1'b0}}} + N_W'(ROUND_HALF);
        x3_next   = num[N_W-1:DIV_SHIFT];
        m4_next   = {{Q_W{1'b0}}, x3_reg} * {{X_W{1'b0}}, RECIP};
        qd_full   = m4_reg[X_W+Q_W-1:X_W] * 14'(DIV_ODD);
        qd5_next  = X_W'(qd_full);
        rem       = x5_reg - qd5_reg;
        q6_next   = q5_reg + Q_W'(rem >= X_W'(DIV_ODD));
    end

    // base plus signed ramp, saturated
    always_comb
    begin
        rest_ext = SUM_W'(rest);
        qs       = signed'({{(SUM_W-Q_W){1'b0}}, q6_reg});
        case (seg6_reg)
            SEG_RISE:  sum = rest_ext + qs;
            SEG_UP:    sum = BASE_UP + qs;
            SEG_DOWN:  sum = BASE_DOWN - qs;
            SEG_RECOV: sum = BASE_RECOV + qs;
            default:   sum = rest_ext;
        endcase
        if (sum > SAT_HI)
        begin
            volt_next = VOLT_W'(SAT_HI);
        end
        else if (sum < SAT_LO)
        begin
            volt_next = VOLT_W'(SAT_LO);
        end
        else
        begin
            volt_next = VOLT_W'(sum);
        end
    end

    always_ff @(posedge clk)
    begin
        seg1_reg <= seg1_next;
        d1_reg   <= d1_next;
        seg2_reg <= seg1_reg;
        p2_reg   <= p2_next;
        seg3_reg <= seg2_reg;
        x3_reg   <= x3_next;
        seg4_reg <= seg3_reg;
        x4_reg   <= x3_reg;
        m4_reg   <= m4_next;
        seg5_reg <= seg4_reg;
        x5_reg   <= x4_reg;
        q5_reg   <= m4_reg[X_W+Q_W-1:X_W];
        qd5_reg  <= qd5_next;
        seg6_reg <= seg5_reg;
        q6_reg   <= q6_next;
        volt_reg <= volt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg <= '0;
        end
        else
        begin
            val_reg <= {val_reg[SHAPE_STAGES-1:1], mod_in.valid};
        end
    end

    assign res_valid = val_reg[SHAPE_STAGES];
    assign res_volt  = volt_reg;

endmodule

>>> rtl/core/action_potential_waveform_gen_core.sv
// ----------------------------------------------------------------------------
// action_potential_waveform_gen_core
// membrane voltage generator: stimulation window, period wrap, spike shape
// ----------------------------------------------------------------------------
// A new time sample may be started in every clock cycle; busy is never
// raised. Each sample yields exactly one voltage on voltage_q8, marked by a
// one-cycle done pulse. Each sample first passes the remainder pipeline,
// which resolves one quotient bit of time / period per stage, followed by
// seven shaping stages. Results cannot be held off and must be taken when
// done is high. Configuration writes are always ready and take effect at
// once, so they belong to times when no sample is in flight.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module action_potential_waveform_gen_core #(
    parameter int TIME_BITS = apwg_pkg::TIME_BITS_DEF,
    parameter int FRAC_BITS = apwg_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [TIME_BITS-1:0]               time_us,
    output logic                               done,
    output logic signed [apwg_pkg::VOLT_W-1:0] voltage_q8,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [apwg_pkg::IDX_W-1:0]         cfg_index,
    input  logic [apwg_pkg::CFG_W-1:0]         cfg_data
);
    import apwg_pkg::*;

    localparam int LATENCY = TIME_BITS - PER_MIN_LOG2 + 1 + SHAPE_STAGES;

    logic [TIME_BITS-1:0]     begin_reg, begin_next;
    logic [TIME_BITS-1:0]     end_reg, end_next;
    logic [PER_W-1:0]         period_reg, period_next;
    logic signed [VOLT_W-1:0] rest_reg, rest_next;
    logic [TIME_BITS-1:0]     cfg_time;
    logic [PER_W-1:0]         cfg_per;
    logic                     accept;
    apwg_mod_out_t            mod_out;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    if (TIME_BITS > CFG_W)
    begin : g_time_wide
        assign cfg_time = {{(TIME_BITS-CFG_W){1'b0}}, cfg_data};
    end
    else
    begin : g_time_narrow
        assign cfg_time = cfg_data[TIME_BITS-1:0];
    end

    assign cfg_per = cfg_data[PER_W-1:0];

    always_comb
    begin
        begin_next  = begin_reg;
        end_next    = end_reg;
        period_next = period_reg;
        rest_next   = rest_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_STIM_BEGIN: begin_next = cfg_time;
                REG_STIM_END:   end_next   = cfg_time;
                REG_PERIOD:
                begin
                    // short periods are raised to the minimum
                    if (cfg_per < PER_W'(MIN_PERIOD))
                    begin
                        period_next = PER_W'(MIN_PERIOD);
                    end
                    else
                    begin
                        period_next = cfg_per;
                    end
                end
                REG_REST:       rest_next  = signed'(cfg_data[VOLT_W-1:0]);
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            begin_reg  <= '0;
            end_reg    <= '0;
            period_reg <= PER_W'(MIN_PERIOD);
            rest_reg   <= VOLT_W'(REST_RESET);
        end
        else
        begin
            begin_reg  <= begin_next;
            end_reg    <= end_next;
            period_reg <= period_next;
            rest_reg   <= rest_next;
        end
    end

    apwg_mod #(
        .TIME_BITS (TIME_BITS)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .in_time   (time_us),
        .win_begin (begin_reg),
        .win_end   (end_reg),
        .period    (period_reg),
        .mod_out   (mod_out)
    );

    apwg_shape #(
        .FRAC_BITS (FRAC_BITS)
    ) u_shape (
        .clk       (clk),
        .rst_n     (rst_n),
        .mod_in    (mod_out),
        .rest      (rest_reg),
        .res_valid (done),
        .res_volt  (voltage_q8)
    );

    `ASSERT_NEVER(a_period_floor, clk, rst_n, period_reg < PER_W'(MIN_PERIOD))
    `ASSERT_AT(a_request_answered, clk, rst_n, accept |-> ##LATENCY done)
    `ASSERT_AT(a_done_has_request, clk, rst_n, done |-> $past(accept, LATENCY))

endmodule

>>> tb/sv/apwg_voltage_checker.sv
// ----------------------------------------------------------------------------
// apwg_voltage_checker
// Watches the sample, result and register channels of the waveform core.
// Every accepted time sample gets an expected membrane voltage. That voltage
// comes from the current window, period and rest settings through the spike
// shape. Each done pulse is compared in order with the oldest voltage still
// outstanding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module apwg_voltage_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic                               busy,
    input  logic [31:0]                        time_us,
    input  logic                               done,
    input  logic signed [apwg_pkg::VOLT_W-1:0] voltage_q8,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [apwg_pkg::IDX_W-1:0]         cfg_index,
    input  logic [apwg_pkg::CFG_W-1:0]         cfg_data,
    output int                                 fail_count,
    output int                                 pending,
    output int                                 compared
);
    import apwg_pkg::*;

    localparam logic [23:0] FLOOR_PERIOD_US = 24'd10000;
    localparam logic signed [15:0] REST_AT_RESET = -16'sd16640;
    localparam longint Q8_ONE = 256;

    typedef struct {
        logic [31:0]        t_us;
        logic signed [15:0] volts;
    } voltage_req_t;

    voltage_req_t expected_voltage_q[$];
    voltage_req_t oldest;

    logic [31:0]        win_lo;
    logic [31:0]        win_hi;
    logic [23:0]        spike_period;
    logic signed [15:0] rest_q8;
    int                 errors;
    int                 compared_n;

    function automatic longint ramp_q8(input longint slope_mv_s, input longint d_us);
        return (slope_mv_s * d_us * Q8_ONE + 500000) / 1000000;
    endfunction

    function automatic logic signed [15:0] voltage_at(input logic [31:0] abs_us);
        logic [31:0] t;
        longint      lt;
        longint      v;
        if (abs_us < win_lo || abs_us > win_hi)
            v = longint'(rest_q8);
        else
        begin
            t = abs_us % {8'd0, spike_period};
            lt = longint'(t);
            if (lt < 1000 || lt >= 7000)
                v = longint'(rest_q8);
            else if (lt < 2500)
                v = longint'(rest_q8) + ramp_q8(8000, lt - 1000);
            else if (lt < 3000)
                v = -53 * Q8_ONE + ramp_q8(160000, lt - 2500);
            else if (lt < 4500)
                v = 27 * Q8_ONE - ramp_q8(62000, lt - 3000);
            else
                v = -66 * Q8_ONE + ramp_q8(400, lt - 4500);
        end
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return 16'(v);
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_lo       = '0;
            win_hi       = '0;
            spike_period = FLOOR_PERIOD_US;
            rest_q8      = REST_AT_RESET;
            errors       = 0;
            compared_n   = 0;
            expected_voltage_q.delete();
            fail_count <= 0;
            pending    <= 0;
            compared   <= 0;
        end
        else
        begin
            if (done !== 1'b0)
            begin
                if (expected_voltage_q.size() == 0)
                    report_mismatch($sformatf("voltage %0d with no request outstanding",
                                              voltage_q8));
                else
                begin
                    oldest = expected_voltage_q.pop_front();
                    compared_n++;
                    if (voltage_q8 !== oldest.volts)
                        report_mismatch($sformatf("time %0d: voltage_q8 %0d, expected %0d",
                                                  oldest.t_us, voltage_q8, oldest.volts));
                end
            end
            if (start && !busy)
                expected_voltage_q.push_back('{t_us: time_us, volts: voltage_at(time_us)});
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_STIM_BEGIN: win_lo = cfg_data;
                    REG_STIM_END:   win_hi = cfg_data;
                    REG_PERIOD:
                        spike_period = (cfg_data[23:0] < FLOOR_PERIOD_US) ?
                                       FLOOR_PERIOD_US : cfg_data[23:0];
                    REG_REST:       rest_q8 = cfg_data[15:0];
                    default: ;
                endcase
            end
            fail_count <= errors;
            pending    <= expected_voltage_q.size();
            compared   <= compared_n;
        end
    end

endmodule

>>> tb/sv/action_potential_waveform_gen_core_tb.sv
// ----------------------------------------------------------------------------
// action_potential_waveform_gen_core_tb
// Top of the waveform core regression. A directed part runs first. It covers
// the reset settings, every segment edge of the spike shape, the period floor
// clamp, saturation at the upper rail and an empty window. Random register
// settings follow, each with time samples drawn mostly around the spike of
// the stimulation window and sent with random gaps or back to back. The
// checker beside the core predicts and compares every voltage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module action_potential_waveform_gen_core_tb;
    import apwg_pkg::*;

    localparam int LIMIT_CYCLES    = 200000;
    localparam int DRAIN_CYCLES    = 40;
    localparam int RANDOM_PHASES   = 14;
    localparam int ITEMS_PER_PHASE = 68;
    localparam int N_SHAPE_EDGES   = 15;

    // segment edges of the spike shape and a wrapped time past the period
    localparam logic [31:0] SHAPE_EDGES_US [N_SHAPE_EDGES] = '{
        32'd999, 32'd1000, 32'd1001, 32'd2499, 32'd2500, 32'd2501, 32'd2999,
        32'd3000, 32'd3001, 32'd4499, 32'd4500, 32'd6999, 32'd7000, 32'd9999,
        32'd12750
    };

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      start     = 1'b0;
    logic                      busy;
    logic [31:0]               time_us   = '0;
    logic                      done;
    logic signed [VOLT_W-1:0]  voltage_q8;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [IDX_W-1:0]          cfg_index = '0;
    logic [CFG_W-1:0]          cfg_data  = '0;

    int          fail_count;
    int          pending;
    int          compared;
    int          cycle_count = 0;
    int          sent        = 0;
    int          settings    = 0;
    bit          no_idle     = 1'b0;
    logic [31:0] cur_lo      = '0;
    logic [31:0] cur_hi      = '0;
    logic [23:0] cur_per     = 24'd10000;

    always #10 clk = ~clk;

    action_potential_waveform_gen_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .time_us    (time_us),
        .done       (done),
        .voltage_q8 (voltage_q8),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    apwg_voltage_checker u_voltage_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .time_us    (time_us),
        .done       (done),
        .voltage_q8 (voltage_q8),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending),
        .compared   (compared)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d voltages outstanding",
                     cycle_count, pending);
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic apply_setting(input logic [31:0] lo, input logic [31:0] hi,
                                 input logic [31:0] per_raw, input logic [31:0] rest_raw);
        write_reg(REG_STIM_BEGIN, lo);
        write_reg(REG_STIM_END, hi);
        write_reg(REG_PERIOD, per_raw);
        write_reg(REG_REST, rest_raw);
        cfg_valid <= 1'b0;
        cur_lo  = lo;
        cur_hi  = hi;
        cur_per = (per_raw[23:0] < 24'd10000) ? 24'd10000 : per_raw[23:0];
        settings++;
    endtask

    task automatic send_time(input logic [31:0] t);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        time_us <= t;
        do @(posedge clk); while (busy);
        sent++;
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // mostly samples near a spike start inside a non-empty window, some at the
    // window bounds, the rest anywhere
    function automatic logic [31:0] spike_time();
        int          pick;
        logic [31:0] anchor;
        pick = $urandom_range(0, 9);
        if (pick <= 5)
        begin
            anchor = (cur_lo <= cur_hi) ? $urandom_range(cur_hi, cur_lo) : $urandom;
            return anchor - anchor % {8'd0, cur_per} + $urandom_range(0, 7999);
        end
        if (pick == 6)
        begin
            case ($urandom_range(0, 3))
                0:       return cur_lo;
                1:       return cur_hi;
                2:       return cur_lo - 1;
                default: return cur_hi + 1;
            endcase
        end
        return $urandom;
    endfunction

    task automatic random_setting(input int ph);
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] per;
        logic [31:0] rest;
        lo = $urandom;
        case ($urandom_range(0, 4))
            0:
            begin
                lo = '0;
                hi = 32'hFFFF_FFFF;
            end
            1: hi = lo + $urandom_range(0, 400000);
            2:
            begin
                lo = $urandom_range(32'hFFFF_FFFF, 1);
                hi = $urandom_range(lo - 1, 0);
            end
            3: hi = lo;
            default: hi = $urandom;
        endcase
        per = $urandom;
        case ($urandom_range(0, 4))
            0: per[23:0] = 24'($urandom_range(0, 9999));
            1: per[23:0] = 24'd10000;
            2: per[23:0] = 24'hFF_FFFF;
            3: per[23:0] = 24'($urandom_range(10000, 30000));
            default: ;
        endcase
        rest = $urandom;
        case ($urandom_range(0, 4))
            0: rest[15:0] = 16'h7FFF;
            1: rest[15:0] = 16'h8000;
            2: rest[15:0] = 16'hBF00;
            default: ;
        endcase
        if (ph < 2)
        begin
            lo = '0;
            hi = 32'hFFFF_FFFF;
            per[23:0]  = (ph == 0) ? 24'hFF_FFFF : 24'd0;
            rest[15:0] = (ph == 0) ? 16'h7FFF : 16'h8000;
        end
        apply_setting(lo, hi, per, rest);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: window is the single point zero
        send_time(32'd0);
        send_time(32'd1);
        send_time(32'hFFFF_FFFF);
        wait_idle();

        // full window, period below the floor, every segment edge
        apply_setting(32'd0, 32'hFFFF_FFFF, 32'd5, 32'hFFFF_BF00);
        for (int i = 0; i < N_SHAPE_EDGES; i++)
            send_time(SHAPE_EDGES_US[i]);
        wait_idle();

        // rest on the rails, upper one saturating on the rising ramp
        apply_setting(32'd0, 32'hFFFF_FFFF, 32'd10000, 32'h0000_7FFF);
        send_time(32'd2499);
        send_time(32'd1500);
        wait_idle();
        apply_setting(32'd0, 32'hFFFF_FFFF, 32'd10000, 32'h0000_8000);
        send_time(32'd1000);
        send_time(32'd500);
        wait_idle();

        // empty window
        apply_setting(32'd1000, 32'd999, 32'hFF_FFFF, 32'h0000_1234);
        send_time(32'd1500);
        send_time(32'd999);
        wait_idle();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            random_setting(ph);
            no_idle = (ph % 4 == 2);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                send_time(spike_time());
                if (i == ITEMS_PER_PHASE / 2 && ph % 3 == 0)
                    wait_idle();
            end
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("%0d time samples sent under %0d register settings, %0d voltages compared",
                 sent, settings, compared);
        $display("windows full, empty and single-point; periods from the floor clamp to 24-bit max");
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
